[rtl/atd_pkg.sv]
// Package for the accelerometer tamper detector.
// Holds the window, width constants and the lane control struct.
// It depends on nothing; every rtl module refers to it by scoped names.
`timescale 1ns / 1ps

package atd_pkg;

  localparam int WIN_LOG2   = 3;
  localparam int WINDOW_LEN = 1 << WIN_LOG2;
  localparam int IDX_W      = (WIN_LOG2 > 0) ? WIN_LOG2 : 1;

  localparam int AXES     = 3;
  localparam int SAMPLE_W = 10;
  localparam int THRESH_W = 20;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(100);

  // Averages drift at most a window's length below a sample's range.
  localparam int AVG_W  = SAMPLE_W + 2;
  localparam int DIFF_W = AVG_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int NUM_W  = AVG_W + WIN_LOG2 + 1;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_PRIME  = 1'b1;

  typedef struct packed {
    logic             accept;
    logic             prime;
    logic [IDX_W-1:0] idx;
  } atd_ctrl_t;

endpackage

[rtl/atd_lane.sv]
// One axis lane of the tamper detector: running average, sample ring,
// registered deviation and its squared threshold check.
// Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  atd_pkg::atd_ctrl_t            ctrl,
  input  logic [atd_pkg::SAMPLE_W-1:0]  sample,
  input  logic [atd_pkg::THRESH_W-1:0]  threshold,
  output logic                          hit
);

  logic signed [atd_pkg::AVG_W-1:0]  avg;
  logic signed [atd_pkg::AVG_W-1:0]  avg_next;
  logic signed [atd_pkg::AVG_W-1:0]  sample_avg;
  logic [atd_pkg::SAMPLE_W-1:0]      ring [atd_pkg::WINDOW_LEN];
  logic signed [atd_pkg::DIFF_W-1:0] diff;
  logic signed [atd_pkg::DIFF_W-1:0] diff_next;
  logic signed [atd_pkg::NUM_W-1:0]  num;
  logic signed [atd_pkg::NUM_W-1:0]  num_adj;
  logic signed [atd_pkg::SQ_W-1:0]   sq;

  always_comb begin
    sample_avg = $signed({{(atd_pkg::AVG_W - atd_pkg::SAMPLE_W){1'b0}}, sample});
    diff_next  = atd_pkg::DIFF_W'(avg) - atd_pkg::DIFF_W'(sample_avg);
    num = (atd_pkg::NUM_W'(avg) <<< atd_pkg::WIN_LOG2)
        - $signed({{(atd_pkg::NUM_W - atd_pkg::SAMPLE_W){1'b0}}, ring[ctrl.idx]})
        + $signed({{(atd_pkg::NUM_W - atd_pkg::SAMPLE_W){1'b0}}, sample});
    // Bias negative sums so that the shift truncates toward zero.
    if (num[atd_pkg::NUM_W-1]) begin
      num_adj = num + $signed(atd_pkg::NUM_W'(atd_pkg::WINDOW_LEN - 1));
    end else begin
      num_adj = num;
    end
    avg_next = $signed(num_adj[atd_pkg::WIN_LOG2 +: atd_pkg::AVG_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
      for (int k = 0; k < atd_pkg::WINDOW_LEN; k++) begin
        ring[k] <= '0;
      end
    end else if (ctrl.accept) begin
      if (ctrl.prime) begin
        avg <= sample_avg;
        for (int k = 0; k < atd_pkg::WINDOW_LEN; k++) begin
          ring[k] <= sample;
        end
      end else begin
        avg            <= avg_next;
        ring[ctrl.idx] <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      diff <= diff_next;
    end
  end

  always_comb begin
    sq  = diff * diff;
    hit = sq > $signed({{(atd_pkg::SQ_W - atd_pkg::THRESH_W){1'b0}}, threshold});
  end

endmodule

[rtl/atd_merge.sv]
// Merge stage of the tamper detector: ORs the lane flags of one beat and
// holds the result register toward the receiver. Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s1_valid,
  input  logic                      s1_prime,
  input  logic [atd_pkg::AXES-1:0]  lane_hit,
  input  logic                      result_stall,
  output logic                      s1_adv,
  output logic                      result_valid,
  output logic                      tamper
);

  logic out_free;
  logic tamper_next;

  always_comb begin
    out_free    = !result_valid || !result_stall;
    s1_adv      = s1_valid && out_free;
    tamper_next = s1_valid && !s1_prime && (|lane_hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      tamper       <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
      tamper       <= tamper_next;
    end
  end

  a_prime_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_prime) |=> !tamper)
    else $error("prime beat produced a tamper flag");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !tamper)
    else $error("tamper set without a valid result");

  a_hold_reason: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> (result_valid && result_stall))
    else $error("stage held while output register could take it");

endmodule

[rtl/accel_tamper_detector_unit.sv]
// Accelerometer tamper detector: three axis lanes working side by side and
// a merge stage that combines their flags. Threshold register is local.
// Depends on atd_pkg, atd_lane and atd_merge.
//
// Usage: each input beat carries func and one 10-bit sample per axis on
// sample_valid/sample_stall. A prime beat (func = 1) loads every axis
// average and ring slot with its sample and returns tamper = 0. An update
// beat compares each axis average with its sample, flags tamper when a
// squared deviation exceeds tamper_threshold, and folds the sample into the
// eight-slot moving average. Every beat returns one result beat on
// result_valid/result_stall. The threshold is written through
// thresh_valid/thresh_ready, which is always ready; the user must write it
// only while no beat is in flight; the block does not enforce this. One
// beat is accepted every cycle while sample_stall is low; a beat's average
// update completes in the cycle it is accepted, and the squared deviation
// check is made in the deviation stage. When the receiver stalls, the
// result register holds and one more beat can wait in the deviation stage
// before sample_stall rises. Reset clears all averages, ring slots and the
// slot index to zero, empties the pipeline and sets the threshold to 100.
`timescale 1ns / 1ps

module accel_tamper_detector_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic                          func,
  input  logic [atd_pkg::SAMPLE_W-1:0]  x_sample,
  input  logic [atd_pkg::SAMPLE_W-1:0]  y_sample,
  input  logic [atd_pkg::SAMPLE_W-1:0]  z_sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          tamper,
  input  logic                          thresh_valid,
  output logic                          thresh_ready,
  input  logic [atd_pkg::THRESH_W-1:0]  tamper_threshold
);

  logic [atd_pkg::THRESH_W-1:0] threshold;
  logic [atd_pkg::IDX_W-1:0]    ring_index;
  logic [atd_pkg::IDX_W-1:0]    ring_index_next;
  logic                         s1_valid;
  logic                         s1_prime;
  logic                         s1_adv;
  logic                         accept;
  logic [atd_pkg::AXES-1:0]     lane_hit;
  logic [atd_pkg::SAMPLE_W-1:0] samples [atd_pkg::AXES];
  atd_pkg::atd_ctrl_t           ctrl;

  assign thresh_ready = 1'b1;

  always_comb begin
    sample_stall = s1_valid && !s1_adv;
    accept       = sample_valid && !sample_stall;
    ctrl.accept  = accept;
    ctrl.prime   = (func == atd_pkg::FUNC_PRIME);
    ctrl.idx     = ring_index;
    samples[0]   = x_sample;
    samples[1]   = y_sample;
    samples[2]   = z_sample;
    if (ring_index == atd_pkg::IDX_W'(atd_pkg::WINDOW_LEN - 1)) begin
      ring_index_next = '0;
    end else begin
      ring_index_next = ring_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= atd_pkg::THRESH_RESET;
    end else if (thresh_valid && thresh_ready) begin
      threshold <= tamper_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_index <= '0;
      s1_valid   <= 1'b0;
      s1_prime   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_prime <= ctrl.prime;
        if (!ctrl.prime) begin
          ring_index <= ring_index_next;
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  for (genvar a = 0; a < atd_pkg::AXES; a++) begin : g_lane
    atd_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sample    (samples[a]),
      .threshold (threshold),
      .hit       (lane_hit[a])
    );
  end

  atd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_prime     (s1_prime),
    .lane_hit     (lane_hit),
    .result_stall (result_stall),
    .s1_adv       (s1_adv),
    .result_valid (result_valid),
    .tamper       (tamper)
  );

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    ring_index <= atd_pkg::IDX_W'(atd_pkg::WINDOW_LEN - 1))
    else $error("ring index beyond window");

  a_prime_keeps_index: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.prime) |=> $stable(ring_index))
    else $error("prime beat moved the ring index");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !sample_stall)
    else $error("input stalled with an empty deviation stage");

endmodule
